// ===== rtl/deadline_timer_queue_assert.svh =====
// Assertion macros for the deadline timer queue.
// Used by modules that check their own control logic; no other dependencies.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DTQ_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dtq assertion failed");

// Implication from one cycle to the next.
`define DTQ_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dtq assertion failed");

`endif

// ===== rtl/dtq_pkg.sv =====
// Shared types and constants of the deadline timer queue.
// No dependencies.
package dtq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int DL_W   = 48;
    localparam int TAG_W  = 32;
    localparam int ORD_W  = 32;
    localparam int PER_W  = 16;
    localparam int CFG_W  = 32;

    localparam logic OPC_TICK = 1'b0;
    localparam logic OPC_ADD  = 1'b1;

    localparam logic CFG_MARKER = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_ADD_RES,
        S_MARK,
        S_SRCH_INIT,
        S_SRCH,
        S_HANDLE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ADD,
        OP_MARK,
        OP_SRCH
    } scan_op_t;

    typedef struct packed {
        scan_op_t op;
        logic     start;
        logic     tick_inc;
        logic     latch;
        logic     emit_add;
        logic     handle;
        logic     emit_done;
    } cmd_t;

    typedef struct packed {
        logic cnt_done;
        logic scan_done;
        logic best_ok;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic              valid;
        logic              pend;
        logic [DL_W-1:0]   dl;
        logic [TAG_W-1:0]  tag;
        logic [ORD_W-1:0]  ord;
    } slot_t;

endpackage

// ===== rtl/dtq_if.sv =====
// Valid/ready stream interfaces for the request and result beats.
// Depends on dtq_pkg for field widths.
interface dtq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [dtq_pkg::DL_W-1:0]          deadline;
    logic signed [dtq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, output opcode, output deadline, output tag, input ready);
    modport sink (input valid, input opcode, input deadline, input tag, output ready);
endinterface

interface dtq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [dtq_pkg::DL_W-1:0]          expired_deadline;
    logic signed [dtq_pkg::TAG_W-1:0]  expired_tag;
    logic                              switch_due;
    logic                              last;

    modport source (output valid, output kind, output expired_deadline, output expired_tag,
                    output switch_due, output last, input ready);
    modport sink (input valid, input kind, input expired_deadline, input expired_tag,
                  input switch_due, input last, output ready);
endinterface

// ===== rtl/dtq_ctrl.sv =====
// Controller of the deadline timer queue: sequences scan passes over the slot store.
// Depends on dtq_pkg.
module dtq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_opcode,
    output logic              in_ready,
    output dtq_pkg::cmd_t     cmd,
    input  dtq_pkg::status_t  sts
);
    import dtq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.cnt_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid) state_next = (in_opcode == OPC_ADD) ? S_ADD : S_MARK;
            end
            S_ADD:
            begin
                if (sts.scan_done) state_next = S_ADD_RES;
            end
            S_ADD_RES:
            begin
                if (sts.out_free) state_next = S_IDLE;
            end
            S_MARK:
            begin
                if (sts.scan_done) state_next = S_SRCH_INIT;
            end
            S_SRCH_INIT:
            begin
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (sts.scan_done) state_next = sts.best_ok ? S_HANDLE : S_DONE;
            end
            S_HANDLE:
            begin
                if (sts.out_free) state_next = S_SRCH_INIT;
            end
            S_DONE:
            begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:     cmd.op = OP_CLEAR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start    = 1'b1;
                    cmd.latch    = 1'b1;
                    cmd.tick_inc = (in_opcode == OPC_TICK);
                end
            end
            S_ADD:       cmd.op = OP_ADD;
            S_ADD_RES:   cmd.emit_add = sts.out_free;
            S_MARK:      cmd.op = OP_MARK;
            S_SRCH_INIT: cmd.start = 1'b1;
            S_SRCH:      cmd.op = OP_SRCH;
            S_HANDLE:    cmd.handle = sts.out_free;
            S_DONE:      cmd.emit_done = sts.out_free;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/dtq_datapath.sv =====
// Datapath of the deadline timer queue: slot memory, scan counter, best-candidate
// registers, tick and sequence counters, configuration and result register. Depends on dtq_pkg.
`include "deadline_timer_queue_assert.svh"

module dtq_datapath #(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dtq_pkg::cmd_t                     cmd,
    output dtq_pkg::status_t                  sts,
    input  logic [dtq_pkg::DL_W-1:0]          in_deadline,
    input  logic signed [dtq_pkg::TAG_W-1:0]  in_tag,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [dtq_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        out_kind,
    output logic [dtq_pkg::DL_W-1:0]          out_deadline,
    output logic signed [dtq_pkg::TAG_W-1:0]  out_tag,
    output logic                              out_switch,
    output logic                              out_last
);
    import dtq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    slot_t mem [DEPTH];

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               rd_ok_reg;
    logic [AW-1:0]      rd_idx_reg;
    slot_t              rd_word_reg;
    logic [DL_W-1:0]    tick_reg;
    logic [ORD_W-1:0]   seq_reg;
    logic [TAG_W-1:0]   marker_reg;
    logic [PER_W-1:0]   period_reg;
    logic               found_reg;
    logic               sw_reg;
    logic [DL_W-1:0]    hold_dl_reg;
    logic [TAG_W-1:0]   hold_tag_reg;
    logic               best_ok_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [DL_W-1:0]    best_dl_reg;
    logic [TAG_W-1:0]   best_tag_reg;
    logic [ORD_W-1:0]   best_ord_reg;
    logic               out_valid_reg;

    logic               cnt_done;
    logic               step;
    logic               add_wr;
    logic               best_sw;
    logic               better;
    logic               out_free;
    logic               out_load;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    slot_t              wr_data;
    logic [PER_W-1:0]   period_eff;

    assign cnt_done   = (cnt_reg == CW'(DEPTH));
    assign step       = !cnt_done && (cmd.op == OP_ADD || cmd.op == OP_MARK
                                      || cmd.op == OP_SRCH);
    assign add_wr     = (cmd.op == OP_ADD) && rd_ok_reg && !rd_word_reg.valid && !found_reg;
    assign best_sw    = (best_tag_reg == marker_reg);
    assign better     = !best_ok_reg || (rd_word_reg.dl < best_dl_reg)
                        || (rd_word_reg.dl == best_dl_reg && rd_word_reg.ord < best_ord_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = cmd.emit_add || cmd.emit_done || (cmd.handle && !best_sw);
    assign period_eff = (period_reg == '0) ? PER_W'(1) : period_reg;

    assign sts.cnt_done  = cnt_done;
    assign sts.scan_done = cnt_done && !rd_ok_reg;
    assign sts.best_ok   = best_ok_reg;
    assign sts.out_free  = out_free;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_word_reg;
        if (cmd.op == OP_CLEAR && !cnt_done)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[AW-1:0];
            wr_data = '0;
        end
        else if (add_wr)
        begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.pend  = 1'b0;
            wr_data.dl    = hold_dl_reg;
            wr_data.tag   = hold_tag_reg;
            wr_data.ord   = seq_reg;
        end
        else if (cmd.op == OP_MARK && rd_ok_reg)
        begin
            wr_en        = 1'b1;
            wr_data.pend = rd_word_reg.valid && (rd_word_reg.dl <= tick_reg);
        end
        else if (cmd.handle)
        begin
            wr_en         = 1'b1;
            wr_addr       = best_idx_reg;
            wr_data.valid = best_sw;
            wr_data.pend  = 1'b0;
            wr_data.dl    = tick_reg + DL_W'(period_eff);
            wr_data.tag   = best_tag_reg;
            wr_data.ord   = seq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (step) rd_word_reg <= mem[cnt_reg[AW-1:0]];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start) cnt_next = '0;
        else if (step || (cmd.op == OP_CLEAR && !cnt_done)) cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            tick_reg      <= '0;
            seq_reg       <= '0;
            marker_reg    <= 32'h8000_0000;
            period_reg    <= PER_W'(2);
            found_reg     <= 1'b0;
            sw_reg        <= 1'b0;
            best_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_ok_reg  <= step;
            rd_idx_reg <= cnt_reg[AW-1:0];
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + DL_W'(1);
                sw_reg   <= 1'b0;
            end
            if (add_wr || (cmd.handle && best_sw)) seq_reg <= seq_reg + ORD_W'(1);
            if (cmd.handle && best_sw) sw_reg <= 1'b1;
            if (cmd.start)
            begin
                found_reg   <= 1'b0;
                best_ok_reg <= 1'b0;
            end
            else
            begin
                if (add_wr) found_reg <= 1'b1;
                if (cmd.op == OP_SRCH && rd_ok_reg && rd_word_reg.pend && better)
                    best_ok_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MARKER: marker_reg <= cfg_wdata;
                    CFG_PERIOD: period_reg <= cfg_wdata[PER_W-1:0];
                    default:    marker_reg <= marker_reg;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            hold_dl_reg  <= in_deadline;
            hold_tag_reg <= in_tag;
        end
        if (cmd.op == OP_SRCH && rd_ok_reg && rd_word_reg.pend && better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_dl_reg  <= rd_word_reg.dl;
            best_tag_reg <= rd_word_reg.tag;
            best_ord_reg <= rd_word_reg.ord;
        end
        if (cmd.emit_add)
        begin
            out_kind     <= found_reg ? KIND_ACCEPT : KIND_FULL;
            out_deadline <= '0;
            out_tag      <= '0;
            out_switch   <= 1'b0;
            out_last     <= 1'b1;
        end
        else if (cmd.emit_done)
        begin
            out_kind     <= KIND_DONE;
            out_deadline <= '0;
            out_tag      <= '0;
            out_switch   <= sw_reg;
            out_last     <= 1'b1;
        end
        else if (out_load)
        begin
            out_kind     <= KIND_EXPIRE;
            out_deadline <= best_dl_reg;
            out_tag      <= best_tag_reg;
            out_switch   <= 1'b0;
            out_last     <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `DTQ_ASSERT(a_load_free, !out_load || !out_valid_reg || out_ready)
    `DTQ_ASSERT(a_one_slot, !(found_reg && add_wr))
    `DTQ_ASSERT(a_handle_best, !cmd.handle || best_ok_reg)
    `DTQ_ASSERT_NEXT(a_cnt_start, cmd.start, cnt_reg == '0)

endmodule

// ===== rtl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_datapath.
//
// Holds up to DEPTH timers in a single-port-read slot memory that every operation scans
// one slot per cycle. After reset a clearing pass over every slot runs before the first
// request is taken. An add scans the whole store for the lowest free slot. A tick marks
// expired slots in one pass, then runs one search pass, including the handling of the
// winner, for each expired timer plus one final pass. One request is in work at a
// time; results wait in an output register.
module deadline_timer_queue #(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    dtq_req_if.sink                    req,
    dtq_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [dtq_pkg::CFG_W-1:0]  cfg_wdata
);
    import dtq_pkg::*;

    cmd_t    cmd;
    status_t sts;

    dtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dtq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_deadline  (req.deadline),
        .in_tag       (req.tag),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_kind     (rsp.kind),
        .out_deadline (rsp.expired_deadline),
        .out_tag      (rsp.expired_tag),
        .out_switch   (rsp.switch_due),
        .out_last     (rsp.last)
    );

endmodule

// ===== tb/tb_deadline_timer_queue.sv =====
// Self-checking testbench for deadline_timer_queue: adds, ticks, expiry order and
// task-switch re-arm, checked beat by beat against an in-bench predictor.
// Depends on dtq_pkg, dtq_if (dtq_req_if, dtq_rsp_if) and the deadline_timer_queue RTL.
module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int NSLOT      = 32;
    localparam int IDLE_PCT   = 17;
    localparam int STALL_LIMIT = 40000;
    localparam int RX_HOLD    = 400;

    typedef struct {
        logic              opc;
        logic [DL_W-1:0]   dl;
        logic [TAG_W-1:0]  tg;
    } timer_req_t;

    typedef struct {
        logic [1:0]        kind;
        logic [DL_W-1:0]   dl;
        logic [TAG_W-1:0]  tg;
        logic              sw;
        logic              last;
    } timer_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    dtq_req_if req ();
    dtq_rsp_if rsp ();

    deadline_timer_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [TAG_W-1:0]  mdl_marker;
    logic [PER_W-1:0]  mdl_period;
    logic [DL_W-1:0]   mdl_ticks;
    logic [ORD_W-1:0]  mdl_seq;
    logic [DL_W-1:0]   mdl_dl  [NSLOT];
    logic [TAG_W-1:0]  mdl_tag [NSLOT];
    logic [ORD_W-1:0]  mdl_ord [NSLOT];
    bit                mdl_vld [NSLOT];

    timer_req_t  pending_reqs [$];
    timer_rsp_t  expected_rsps [$];
    timer_req_t  cur_req;

    int  mismatches;
    int  rsp_count;
    int  req_count;
    int  stall_cycles;
    int  hold_cnt;
    bit  hold_done;
    bit  calm;
    logic [DL_W-1:0] gen_ticks;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic predict_timer(input timer_req_t r);
        int i;
        int best;
        bit pend [NSLOT];
        bit sw;
        bit placed;
        logic [DL_W-1:0] per;
        timer_rsp_t o;
        begin
            if (r.opc == OPC_ADD)
            begin
                placed = 0;
                for (i = 0; i < NSLOT; i++)
                begin
                    if (!placed && !mdl_vld[i])
                    begin
                        mdl_vld[i] = 1;
                        mdl_dl[i]  = r.dl;
                        mdl_tag[i] = r.tg;
                        mdl_ord[i] = mdl_seq;
                        mdl_seq    = mdl_seq + 1;
                        placed     = 1;
                    end
                end
                o = '{placed ? KIND_ACCEPT : KIND_FULL, '0, '0, 1'b0, 1'b1};
                expected_rsps.push_back(o);
            end
            else
            begin
                sw  = 0;
                per = (mdl_period == 0) ? 48'd1 : {32'd0, mdl_period};
                mdl_ticks = mdl_ticks + 1;
                for (i = 0; i < NSLOT; i++)
                    pend[i] = mdl_vld[i] && (mdl_dl[i] <= mdl_ticks);
                forever
                begin
                    best = -1;
                    for (i = 0; i < NSLOT; i++)
                        if (pend[i] && (best < 0 || mdl_dl[i] < mdl_dl[best] ||
                            (mdl_dl[i] == mdl_dl[best] && mdl_ord[i] < mdl_ord[best])))
                            best = i;
                    if (best < 0)
                        break;
                    pend[best] = 0;
                    if (mdl_tag[best] == mdl_marker)
                    begin
                        sw = 1;
                        mdl_dl[best]  = mdl_ticks + per;
                        mdl_ord[best] = mdl_seq;
                        mdl_seq       = mdl_seq + 1;
                    end
                    else
                    begin
                        o = '{KIND_EXPIRE, mdl_dl[best], mdl_tag[best], 1'b0, 1'b0};
                        expected_rsps.push_back(o);
                        mdl_vld[best] = 0;
                    end
                end
                o = '{KIND_DONE, '0, '0, sw, 1'b1};
                expected_rsps.push_back(o);
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid    <= 1'b0;
            req.opcode   <= OPC_TICK;
            req.deadline <= '0;
            req.tag      <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_timer(cur_req);
                req_count <= req_count + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_req = pending_reqs.pop_front();
                    req.valid    <= 1'b1;
                    req.opcode   <= cur_req.opc;
                    req.deadline <= cur_req.dl;
                    req.tag      <= cur_req.tg;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor, receiver stall and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                timer_rsp_t e;
                rsp_count = rsp_count + 1;
                if (expected_rsps.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected beat: kind=%0d dl=%0h tag=%0h sw=%0b last=%0b",
                                 rsp.kind, rsp.expired_deadline, rsp.expired_tag,
                                 rsp.switch_due, rsp.last);
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.kind !== e.kind || rsp.expired_deadline !== e.dl ||
                        rsp.expired_tag !== e.tg || rsp.switch_due !== e.sw ||
                        rsp.last !== e.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch beat %0d: exp kind=%0d dl=%0h tag=%0h sw=%0b last=%0b",
                                     rsp_count, e.kind, e.dl, e.tg, e.sw, e.last);
                            $display("  got kind=%0d dl=%0h tag=%0h sw=%0b last=%0b",
                                     rsp.kind, rsp.expired_deadline, rsp.expired_tag,
                                     rsp.switch_due, rsp.last);
                        end
                    end
                end
            end
            if (!hold_done && rsp_count >= 30)
            begin
                hold_done = 1;
                hold_cnt  = RX_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_deadline_timer_queue: done, errors");
                $finish;
            end
        end
    end

    task automatic push_add(input logic [DL_W-1:0] dl, input logic [TAG_W-1:0] tg);
        timer_req_t r;
        begin
            r = '{OPC_ADD, dl, tg};
            pending_reqs.push_back(r);
        end
    endtask

    task automatic push_tick();
        timer_req_t r;
        begin
            r = '{OPC_TICK, '0, '0};
            pending_reqs.push_back(r);
            gen_ticks = gen_ticks + 1;
        end
    endtask

    task automatic drain();
        begin
            while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
                @(posedge clk);
            repeat (3 * NSLOT) @(posedge clk);
        end
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] data);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_MARKER)
                mdl_marker = data;
            else
                mdl_period = data[PER_W-1:0];
        end
    endtask

    task automatic random_phase(input int n);
        int k;
        int sel;
        logic [DL_W-1:0] dl;
        logic [TAG_W-1:0] tg;
        begin
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 80)
                        dl = gen_ticks + $urandom_range(0, 6);
                    else if (sel < 90)
                        dl = (gen_ticks > 3) ? gen_ticks - $urandom_range(0, 3) : '0;
                    else if (sel < 95)
                        dl = DL_W'({$urandom(), $urandom()});
                    else
                        dl = gen_ticks + 2;
                    tg = ($urandom_range(0, 99) < 6) ? mdl_marker : $urandom();
                    push_add(dl, tg);
                end
                else
                    push_tick();
            end
        end
    endtask

    initial
    begin
        int k;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MARKER;
        cfg_wdata  = '0;
        mismatches = 0;
        rsp_count  = 0;
        req_count  = 0;
        stall_cycles = 0;
        hold_cnt   = 0;
        hold_done  = 0;
        calm       = 0;
        gen_ticks  = '0;
        mdl_marker = 32'h8000_0000;
        mdl_period = 16'd2;
        mdl_ticks  = '0;
        mdl_seq    = '0;
        for (k = 0; k < NSLOT; k++)
            mdl_vld[k] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty tick, extremes, switch timer at reset marker, ties
        push_tick();
        push_add('0, '0);
        push_add({DL_W{1'b1}}, 32'hFFFF_FFFF);
        push_add(48'd2, 32'h8000_0000);
        push_add(48'd3, 32'h7FFF_FFFF);
        push_add(48'd3, 32'd1);
        push_add(48'd3, 32'd2);
        push_add(48'd2, 32'h8000_0001);
        for (k = 0; k < 6; k++)
            push_tick();
        drain();

        write_cfg(CFG_MARKER, 32'd7);
        write_cfg(CFG_PERIOD, 32'd1);
        push_add(gen_ticks + 1, 32'd7);
        push_add(gen_ticks + 1, 32'd7);
        push_tick();
        push_tick();
        random_phase(30);
        drain();

        // fill the store, refuse, then expire everything at once
        write_cfg(CFG_MARKER, 32'h7FFF_FFFF);
        write_cfg(CFG_PERIOD, 32'd65535);
        calm = 1;
        for (k = 0; k < NSLOT + 2; k++)
            push_add(gen_ticks + 3, $urandom());
        for (k = 0; k < 4; k++)
            push_tick();
        random_phase(25);
        drain();
        calm = 0;

        write_cfg(CFG_MARKER, $urandom());
        write_cfg(CFG_PERIOD, 32'd3);
        random_phase(30);
        drain();

        write_cfg(CFG_MARKER, 32'hFFFF_FFFB);
        write_cfg(CFG_PERIOD, $urandom_range(1, 65535));
        random_phase(30);
        drain();

        $display("covered %0d requests and %0d result beats over five register settings,",
                 req_count, rsp_count);
        $display("including a full store, refused adds, tie order and switch re-arms");
        if (mismatches == 0)
            $display("tb_deadline_timer_queue: done, clean");
        else
            $display("tb_deadline_timer_queue: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_if.sv
rtl/dtq_ctrl.sv
rtl/dtq_datapath.sv
rtl/deadline_timer_queue.sv
tb/tb_deadline_timer_queue.sv
